// ----- design/sotl_pkg.sv -----
// Shared types for the self-organising transpose list.
// Holds mode/status codes, controller states and the controller/datapath bundles.
// No dependencies.
package sotl_pkg;

  typedef enum logic [1:0] {
    MODE_APPEND    = 2'd0,
    MODE_SEARCH    = 2'd1,
    MODE_TRANSPOSE = 2'd2,
    MODE_READ      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SWAP_UP,
    S_SWAP_DOWN,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // input transaction taken this cycle
    logic search;     // one step of the list walk
    logic swap_up;    // write the hit value one place nearer the front
    logic swap_down;  // write the displaced entry into the hit slot
    logic finish;     // load the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic match;      // compared entry equals the key
    logic at_front;   // compared entry is position zero
    logic exhausted;  // walk finished without a hit
    logic out_free;   // output register can take a result
  } stat_t;

endpackage

// ----- design/self_organizing_transpose_list_core.sv -----
// Self-organising list with the transpose rule, LIST_DEPTH signed 32-bit entries.
// Append and read: the result loads into the output register from the done state.
// Search: one memory read per cycle down the list until a hit or the end of the list;
// a transpose hit not at the front adds a swap-up and a swap-down write.
// One request at a time, next taken the cycle after the result loads (it may wait there).
// Reset (async, active low) empties the list; entry storage itself is not cleared.
module self_organizing_transpose_list_core import sotl_pkg::*; #(
  parameter int LIST_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] value_i,
  input  logic [7:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [7:0]         found_position_o,
  output logic signed [31:0] read_value_o,
  output logic [8:0]         entry_count_o
);

  cmd_t  cmd;
  stat_t stat;

  sotl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  sotl_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .mode_i           (mode_i),
    .value_i          (value_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .read_value_o     (read_value_o),
    .entry_count_o    (entry_count_o)
  );

endmodule

// ----- design/sotl_ctrl.sv -----
// Controller for the self-organising transpose list.
// Sequences append, search, transpose swap and read; depends on sotl_pkg.
module sotl_ctrl import sotl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  [1:0] mode_i,
  input  stat_t stat_i,
  output logic  in_ready_o,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  mode_e  mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_o.capture) begin
      mode_q <= mode_e'(mode_i);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (mode_e'(mode_i))
            MODE_SEARCH, MODE_TRANSPOSE: state_d = S_SEARCH;
            default:                     state_d = S_DONE;
          endcase
        end
      end
      S_SEARCH: begin
        if (stat_i.match) begin
          if (mode_q == MODE_TRANSPOSE && !stat_i.at_front) begin
            state_d = S_SWAP_UP;
          end else begin
            state_d = S_DONE;
          end
        end else if (stat_i.exhausted) begin
          state_d = S_DONE;
        end
      end
      S_SWAP_UP:   state_d = S_SWAP_DOWN;
      S_SWAP_DOWN: state_d = S_DONE;
      S_DONE: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == S_IDLE);
    cmd_o         = '0;
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    cmd_o.search  = (state_q == S_SEARCH);
    cmd_o.swap_up   = (state_q == S_SWAP_UP);
    cmd_o.swap_down = (state_q == S_SWAP_DOWN);
    cmd_o.finish  = (state_q == S_DONE) && stat_i.out_free;
  end

endmodule

// ----- design/sotl_dp.sv -----
// Datapath for the self-organising transpose list: entry memory, walk
// counters, compare stage and output register. Depends on sotl_pkg.
module sotl_dp import sotl_pkg::*; #(
  parameter int LIST_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] value_i,
  input  logic [7:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [7:0]         found_position_o,
  output logic signed [31:0] read_value_o,
  output logic [8:0]         entry_count_o
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic [31:0] mem [LIST_DEPTH];
  logic [31:0] rd_q;

  mode_e          mode_q;
  logic [31:0]    key_q;
  logic [CW-1:0]  count_q;
  logic           full_q;
  logic           in_range_q;
  logic [CW-1:0]  issue_q;
  logic           cmp_vld_q;
  logic [AW-1:0]  cmp_idx_q;
  logic [31:0]    prev_q;
  logic           hit_q;
  logic [AW-1:0]  hit_idx_q;

  logic           out_valid_q;
  status_e        status_q;
  logic [7:0]     found_q;
  logic [31:0]    rdval_q;
  logic [8:0]     ecount_q;

  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  logic [31:0]    wdata;
  logic           match;
  logic           walk_rd;
  logic           append_ok;
  logic [AW-1:0]  hit_pos;
  status_e        status_d;

  assign match     = cmd_i.search && cmp_vld_q && (rd_q == key_q);
  assign walk_rd   = cmd_i.search && !match && (issue_q < count_q);
  assign append_ok = cmd_i.capture && (mode_e'(mode_i) == MODE_APPEND) &&
                     (count_q < CW'(LIST_DEPTH));

  // one write and one read port
  always_comb begin
    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = value_i;
    if (append_ok) begin
      we = 1'b1;
    end else if (cmd_i.swap_up) begin
      we    = 1'b1;
      waddr = hit_idx_q - AW'(1);
      wdata = key_q;
    end else if (cmd_i.swap_down) begin
      we    = 1'b1;
      waddr = hit_idx_q;
      wdata = prev_q;
    end
    re    = walk_rd || (cmd_i.capture && (mode_e'(mode_i) == MODE_READ));
    raddr = cmd_i.capture ? AW'(position_i) : issue_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (append_ok) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.capture) begin
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.search) begin
        cmp_vld_q <= walk_rd;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q     <= mode_e'(mode_i);
      key_q      <= value_i;
      full_q     <= !(count_q < CW'(LIST_DEPTH));
      in_range_q <= (32'(position_i) < 32'(count_q)) &&
                    (32'(position_i) < 32'(LIST_DEPTH));
      issue_q    <= '0;
      hit_q      <= 1'b0;
    end else if (cmd_i.search) begin
      if (walk_rd) begin
        issue_q   <= issue_q + CW'(1);
        cmp_idx_q <= issue_q[AW-1:0];
      end
      if (match) begin
        hit_q     <= 1'b1;
        hit_idx_q <= cmp_idx_q;
      end else if (cmp_vld_q) begin
        // keeps the entry in front of the next compare for the swap
        prev_q <= rd_q;
      end
    end
  end

  assign hit_pos = (mode_q == MODE_TRANSPOSE && hit_idx_q != '0) ?
                   hit_idx_q - AW'(1) : hit_idx_q;

  always_comb begin
    case (mode_q)
      MODE_APPEND: status_d = full_q ? ST_FULL : ST_OK;
      MODE_READ:   status_d = in_range_q ? ST_OK : ST_RANGE;
      default:     status_d = hit_q ? ST_OK : ST_MISS;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= status_d;
      found_q  <= ((mode_q == MODE_SEARCH || mode_q == MODE_TRANSPOSE) && hit_q) ?
                  8'(hit_pos) : 8'd0;
      rdval_q  <= (mode_q == MODE_READ && in_range_q) ? rd_q : 32'd0;
      ecount_q <= 9'(count_q);
    end
  end

  always_comb begin
    stat_o           = '0;
    stat_o.match     = match;
    stat_o.at_front  = (cmp_idx_q == '0);
    stat_o.exhausted = !cmp_vld_q && !(issue_q < count_q);
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_position_o = found_q;
  assign read_value_o     = rdval_q;
  assign entry_count_o    = ecount_q;

endmodule
